// ----- src/ppa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared constants, codes and types of the physical page allocator.
// ----------------------------------------------------------------------------
package ppa_pkg;

	localparam int PNB_DEF         = 20;
	localparam int MAX_EXT_DEF     = 64;
	localparam int STACK_DEPTH_DEF = 512;

	localparam int LEN_W  = 21;
	localparam int PAGE_W = 20;
	localparam int ACT_W  = 3;
	localparam int ST_W   = 2;
	localparam int CFG_AW = 4;
	localparam int IN_DW  = 48;
	localparam int OUT_DW = 48;

	localparam logic [ACT_W-1:0] ACT_INIT       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RUN_ALLOC  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RUN_FREE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PAGE_ALLOC = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PAGE_FREE  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK         = 2'd0;
	localparam logic [ST_W-1:0] ST_NOMEM      = 2'd1;
	localparam logic [ST_W-1:0] ST_TABLE_FULL = 2'd2;
	localparam logic [ST_W-1:0] ST_STACK_FULL = 2'd3;

	localparam logic [1:0] REG_MULTI_BASE  = 2'd0;
	localparam logic [1:0] REG_SINGLE_BASE = 2'd1;
	localparam logic [1:0] REG_END         = 2'd2;

	localparam logic [PAGE_W-1:0] RST_MULTI_BASE  = 20'd524288;
	localparam logic [PAGE_W-1:0] RST_SINGLE_BASE = 20'd525424;
	localparam logic [LEN_W-1:0]  RST_END         = 21'd525824;

	localparam logic [3:0] OP_NONE       = 4'd0;
	localparam logic [3:0] OP_DECODE     = 4'd1;
	localparam logic [3:0] OP_INIT_PUSH  = 4'd2;
	localparam logic [3:0] OP_SCAN_RD    = 4'd3;
	localparam logic [3:0] OP_SCAN_CHK   = 4'd4;
	localparam logic [3:0] OP_FSCAN_RD   = 4'd5;
	localparam logic [3:0] OP_FSCAN_CHK  = 4'd6;
	localparam logic [3:0] OP_FREE_APPLY = 4'd7;
	localparam logic [3:0] OP_DN_RD      = 4'd8;
	localparam logic [3:0] OP_DN_WR      = 4'd9;
	localparam logic [3:0] OP_UP_RD      = 4'd10;
	localparam logic [3:0] OP_UP_WR      = 4'd11;
	localparam logic [3:0] OP_INS_PUT    = 4'd12;
	localparam logic [3:0] OP_POP_RD     = 4'd13;
	localparam logic [3:0] OP_POP_DATA   = 4'd14;
	localparam logic [3:0] OP_DONE       = 4'd15;

	typedef struct packed {
		logic       load;
		logic [3:0] op;
	} ppa_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic count_zero;
		logic stack_empty;
		logic stack_full;
		logic below_single;
		logic scan_end;
		logic hit;
		logic exact;
		logic left_of;
		logic merge_prev;
		logic merge_next;
		logic table_full;
		logic dn_end;
		logic up_end;
		logic push_done;
		logic out_free;
	} ppa_stat_t;

	function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
		input logic [LEN_W-1:0] b);
		logic [LEN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
	endfunction

endpackage

// ----- src/ppa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/ppa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_ctrl
// Sequencer: walks each transaction through table scans, shifts and stack operations.
// ----------------------------------------------------------------------------
module ppa_ctrl import ppa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ppa_stat_t stat,
	output ppa_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_DECODE     = 4'd1;
	localparam logic [3:0] S_INIT_PUSH  = 4'd2;
	localparam logic [3:0] S_SCAN_RD    = 4'd3;
	localparam logic [3:0] S_SCAN_CHK   = 4'd4;
	localparam logic [3:0] S_FSCAN_RD   = 4'd5;
	localparam logic [3:0] S_FSCAN_CHK  = 4'd6;
	localparam logic [3:0] S_FREE_APPLY = 4'd7;
	localparam logic [3:0] S_DN_RD      = 4'd8;
	localparam logic [3:0] S_DN_WR      = 4'd9;
	localparam logic [3:0] S_UP_RD      = 4'd10;
	localparam logic [3:0] S_UP_WR      = 4'd11;
	localparam logic [3:0] S_INS_PUT    = 4'd12;
	localparam logic [3:0] S_POP_RD     = 4'd13;
	localparam logic [3:0] S_POP_DATA   = 4'd14;
	localparam logic [3:0] S_DONE       = 4'd15;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.op = OP_DECODE;
				case (stat.act)
					ACT_INIT:       state_d = S_INIT_PUSH;
					ACT_RUN_ALLOC:  state_d = stat.count_zero ? S_DONE : S_SCAN_RD;
					ACT_RUN_FREE:   state_d = stat.count_zero ? S_DONE : S_FSCAN_RD;
					ACT_PAGE_ALLOC: state_d = stat.stack_empty ? S_SCAN_RD : S_POP_RD;
					ACT_PAGE_FREE:  state_d = stat.below_single ? S_FSCAN_RD : S_DONE;
					default:        state_d = S_DONE;
				endcase
			end
			S_INIT_PUSH: begin
				cmd.op = OP_INIT_PUSH;
				if (stat.push_done) begin
					state_d = S_DONE;
				end
			end
			S_SCAN_RD: begin
				cmd.op  = OP_SCAN_RD;
				state_d = stat.scan_end ? S_DONE : S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				cmd.op = OP_SCAN_CHK;
				if (stat.hit) begin
					state_d = stat.exact ? S_DN_RD : S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_FSCAN_RD: begin
				cmd.op  = OP_FSCAN_RD;
				state_d = stat.scan_end ? S_FREE_APPLY : S_FSCAN_CHK;
			end
			S_FSCAN_CHK: begin
				cmd.op  = OP_FSCAN_CHK;
				state_d = stat.left_of ? S_FSCAN_RD : S_FREE_APPLY;
			end
			S_FREE_APPLY: begin
				cmd.op = OP_FREE_APPLY;
				if (stat.merge_prev && stat.merge_next) begin
					state_d = S_DN_RD;
				end else if (stat.merge_prev || stat.merge_next || stat.table_full) begin
					state_d = S_DONE;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_DN_RD: begin
				cmd.op  = OP_DN_RD;
				state_d = stat.dn_end ? S_DONE : S_DN_WR;
			end
			S_DN_WR: begin
				cmd.op  = OP_DN_WR;
				state_d = S_DN_RD;
			end
			S_UP_RD: begin
				cmd.op  = OP_UP_RD;
				state_d = stat.up_end ? S_INS_PUT : S_UP_WR;
			end
			S_UP_WR: begin
				cmd.op  = OP_UP_WR;
				state_d = S_UP_RD;
			end
			S_INS_PUT: begin
				cmd.op  = OP_INS_PUT;
				state_d = S_DONE;
			end
			S_POP_RD: begin
				cmd.op  = OP_POP_RD;
				state_d = S_POP_DATA;
			end
			S_POP_DATA: begin
				cmd.op  = OP_POP_DATA;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.op = OP_DONE;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/ppa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_dp
// Datapath: extent table, page stack, counters, config and result registers.
// ----------------------------------------------------------------------------
module ppa_dp import ppa_pkg::*; #(
	parameter int PAGE_NUMBER_BITS   = PNB_DEF,
	parameter int MAX_EXTENTS        = MAX_EXT_DEF,
	parameter int SINGLE_STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ppa_cmd_t          cmd,
	output ppa_stat_t         stat,
	input  logic [ACT_W-1:0]  in_action,
	input  logic [PAGE_W-1:0] in_page,
	input  logic [LEN_W-1:0]  in_count,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ST_W-1:0]   out_status,
	output logic [PAGE_W-1:0] out_granted,
	output logic [LEN_W-1:0]  out_idle
);

	localparam int PNB = PAGE_NUMBER_BITS;
	localparam int EA  = $clog2(MAX_EXTENTS);
	localparam int ECW = $clog2(MAX_EXTENTS + 1);
	localparam int SA  = (SINGLE_STACK_DEPTH > 1) ? $clog2(SINGLE_STACK_DEPTH) : 1;
	localparam int SCW = $clog2(SINGLE_STACK_DEPTH + 1);
	localparam int AW  = ((PNB > LEN_W) ? PNB : LEN_W) + 2;
	localparam int EW  = PNB + LEN_W;
	localparam logic [AW-1:0] PAGE_LIMIT = AW'(1) << PNB;

	logic [ACT_W-1:0] action_q;
	logic [PNB-1:0]   page_q, granted_q, prev_start_q, cur_start_q;
	logic [LEN_W-1:0] count_q, n_q, prev_len_q, cur_len_q;
	logic [ST_W-1:0]  status_q;
	logic [ECW-1:0]   idx_q, k_q, ext_cnt_q;
	logic [LEN_W-1:0] mft_q;
	logic [SCW-1:0]   sdepth_q, push_n_q;
	logic             has_prev_q, has_cur_q;
	logic [PAGE_W-1:0] multi_base_q, single_base_q;
	logic [LEN_W-1:0]  end_q;
	logic              out_valid_q;
	logic [ST_W-1:0]   out_status_q;
	logic [PAGE_W-1:0] out_granted_q;
	logic [LEN_W-1:0]  out_idle_q;

	logic           ext_we;
	logic [EA-1:0]  ext_waddr, ext_raddr;
	logic [EW-1:0]  ext_wdata, ext_rdata;
	logic           stk_we;
	logic [SA-1:0]  stk_waddr, stk_raddr;
	logic [PNB-1:0] stk_wdata, stk_rdata;

	logic [AW-1:0]    page_in_w, page_aw, n_aw, end_aw, sb_aw, mb_aw, top_aw, span_aw;
	logic [AW-1:0]    free_n_aw, grant_aw, push_aw, gout_aw;
	logic [PNB-1:0]   rd_start;
	logic [LEN_W-1:0] rd_len;
	logic [ECW-1:0]   idx_p1, idx_m1, k_m1;
	logic [SCW-1:0]   sdepth_m1;
	logic             init_ext, init_ovf, push_ok, cfg_wr;

	assign page_in_w = AW'(in_page) & (PAGE_LIMIT - AW'(1));
	assign page_aw   = AW'(page_q);
	assign n_aw      = AW'(n_q);
	assign end_aw    = (AW'(end_q) > PAGE_LIMIT) ? PAGE_LIMIT : AW'(end_q);
	assign sb_aw     = AW'(single_base_q);
	assign mb_aw     = AW'(multi_base_q);
	assign top_aw    = (sb_aw < end_aw) ? sb_aw : end_aw;
	assign span_aw   = end_aw - sb_aw;
	assign init_ext  = mb_aw < top_aw;
	assign init_ovf  = (sb_aw < end_aw) && (span_aw > AW'(SINGLE_STACK_DEPTH));
	assign free_n_aw = (page_aw + AW'(count_q) > PAGE_LIMIT) ? PAGE_LIMIT - page_aw
		: AW'(count_q);
	assign rd_start  = ext_rdata[PNB-1:0];
	assign rd_len    = ext_rdata[EW-1:PNB];
	assign grant_aw  = AW'(rd_start) + AW'(rd_len) - n_aw;
	assign push_aw   = sb_aw + AW'(sdepth_q);
	assign gout_aw   = AW'(granted_q);
	assign idx_p1    = idx_q + ECW'(1);
	assign idx_m1    = idx_q - ECW'(1);
	assign k_m1      = k_q - ECW'(1);
	assign sdepth_m1 = sdepth_q - SCW'(1);
	assign push_ok   = !stat.below_single && !stat.stack_full;
	assign cfg_wr    = psel && penable && pwrite;

	always_comb begin
		stat.act          = action_q;
		stat.count_zero   = count_q == '0;
		stat.stack_empty  = sdepth_q == '0;
		stat.stack_full   = sdepth_q >= SCW'(SINGLE_STACK_DEPTH);
		stat.below_single = page_aw < sb_aw;
		stat.scan_end     = idx_q == ext_cnt_q;
		stat.hit          = rd_len >= n_q;
		stat.exact        = rd_len == n_q;
		stat.left_of      = AW'(rd_start) <= page_aw;
		stat.merge_prev   = has_prev_q && (AW'(prev_start_q) + AW'(prev_len_q) == page_aw);
		stat.merge_next   = has_cur_q && (page_aw + n_aw == AW'(cur_start_q));
		stat.table_full   = ext_cnt_q >= ECW'(MAX_EXTENTS);
		stat.dn_end       = ({1'b0, idx_q} + (ECW + 1)'(1)) >= {1'b0, ext_cnt_q};
		stat.up_end       = k_q == idx_q;
		stat.push_done    = sdepth_q == push_n_q;
		stat.out_free     = !out_valid_q || out_ready;
	end

	// table port steering
	always_comb begin
		ext_we    = 1'b0;
		ext_waddr = idx_q[EA-1:0];
		ext_wdata = '0;
		ext_raddr = idx_q[EA-1:0];
		case (cmd.op)
			OP_DECODE: begin
				if (action_q == ACT_INIT && init_ext) begin
					ext_we    = 1'b1;
					ext_waddr = '0;
					ext_wdata = {LEN_W'(top_aw - mb_aw), mb_aw[PNB-1:0]};
				end
			end
			OP_SCAN_CHK: begin
				if (stat.hit && !stat.exact) begin
					ext_we    = 1'b1;
					ext_wdata = {rd_len - n_q, rd_start};
				end
			end
			OP_FREE_APPLY: begin
				if (stat.merge_prev) begin
					ext_we    = 1'b1;
					ext_waddr = idx_m1[EA-1:0];
					ext_wdata = {stat.merge_next
						? sat_add(prev_len_q, sat_add(n_q, cur_len_q))
						: sat_add(prev_len_q, n_q), prev_start_q};
				end else if (stat.merge_next) begin
					ext_we    = 1'b1;
					ext_wdata = {sat_add(cur_len_q, n_q), page_q};
				end
			end
			OP_DN_RD: ext_raddr = idx_p1[EA-1:0];
			OP_DN_WR: begin
				ext_we    = 1'b1;
				ext_wdata = ext_rdata;
			end
			OP_UP_RD: ext_raddr = k_m1[EA-1:0];
			OP_UP_WR: begin
				ext_we    = 1'b1;
				ext_waddr = k_q[EA-1:0];
				ext_wdata = ext_rdata;
			end
			OP_INS_PUT: begin
				ext_we    = 1'b1;
				ext_wdata = {n_q, page_q};
			end
			default: ;
		endcase
	end

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = sdepth_q[SA-1:0];
		stk_wdata = page_q;
		stk_raddr = sdepth_m1[SA-1:0];
		case (cmd.op)
			OP_INIT_PUSH: begin
				stk_we    = !stat.push_done;
				stk_wdata = push_aw[PNB-1:0];
			end
			OP_DECODE: stk_we = (action_q == ACT_PAGE_FREE) && push_ok;
			default: ;
		endcase
	end

	ppa_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_ext_ram (
		.clk   (clk),
		.we    (ext_we),
		.waddr (ext_waddr),
		.wdata (ext_wdata),
		.raddr (ext_raddr),
		.rdata (ext_rdata)
	);

	ppa_ram #(.WIDTH(PNB), .DEPTH(SINGLE_STACK_DEPTH)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= in_action;
			page_q     <= page_in_w[PNB-1:0];
			count_q    <= in_count;
			status_q   <= ST_OK;
			granted_q  <= '0;
			idx_q      <= '0;
			has_prev_q <= 1'b0;
			has_cur_q  <= 1'b0;
		end
		case (cmd.op)
			OP_DECODE: begin
				case (action_q)
					ACT_INIT: begin
						if (sb_aw < end_aw) begin
							push_n_q <= init_ovf ? SCW'(SINGLE_STACK_DEPTH) : span_aw[SCW-1:0];
						end else begin
							push_n_q <= '0;
						end
						if (init_ovf) begin
							status_q <= ST_STACK_FULL;
						end
					end
					ACT_RUN_ALLOC: begin
						n_q <= count_q;
						if (stat.count_zero) begin
							status_q <= ST_NOMEM;
						end
					end
					ACT_RUN_FREE: n_q <= free_n_aw[LEN_W-1:0];
					ACT_PAGE_ALLOC: n_q <= LEN_W'(1);
					ACT_PAGE_FREE: begin
						n_q <= LEN_W'(1);
						if (!stat.below_single && stat.stack_full) begin
							status_q <= ST_STACK_FULL;
						end
					end
					default: ;
				endcase
			end
			OP_SCAN_RD: begin
				if (stat.scan_end) begin
					status_q <= ST_NOMEM;
				end
			end
			OP_SCAN_CHK: begin
				if (stat.hit) begin
					granted_q <= grant_aw[PNB-1:0];
				end else begin
					idx_q <= idx_p1;
				end
			end
			OP_FSCAN_CHK: begin
				if (stat.left_of) begin
					prev_start_q <= rd_start;
					prev_len_q   <= rd_len;
					has_prev_q   <= 1'b1;
					idx_q        <= idx_p1;
				end else begin
					cur_start_q <= rd_start;
					cur_len_q   <= rd_len;
					has_cur_q   <= 1'b1;
				end
			end
			OP_FREE_APPLY: begin
				if (!stat.merge_prev && !stat.merge_next) begin
					if (stat.table_full) begin
						status_q <= ST_TABLE_FULL;
					end
					k_q <= ext_cnt_q;
				end
			end
			OP_DN_WR: idx_q <= idx_p1;
			OP_UP_WR: k_q <= k_m1;
			OP_POP_DATA: granted_q <= stk_rdata;
			OP_DONE: begin
				if (stat.out_free) begin
					out_status_q  <= status_q;
					out_granted_q <= (status_q != ST_OK) ? '0 : gout_aw[PAGE_W-1:0];
					out_idle_q    <= sat_add(mft_q, LEN_W'(sdepth_q));
				end
			end
			default: ;
		endcase
	end

	// counters, config and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_cnt_q     <= '0;
			mft_q         <= '0;
			sdepth_q      <= '0;
			out_valid_q   <= 1'b0;
			multi_base_q  <= RST_MULTI_BASE;
			single_base_q <= RST_SINGLE_BASE;
			end_q         <= RST_END;
		end else begin
			if (cmd.op == OP_DONE && stat.out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_DECODE: begin
					if (action_q == ACT_INIT) begin
						ext_cnt_q <= init_ext ? ECW'(1) : '0;
						mft_q     <= init_ext ? LEN_W'(top_aw - mb_aw) : '0;
						sdepth_q  <= '0;
					end else if (action_q == ACT_PAGE_FREE && push_ok) begin
						sdepth_q <= sdepth_q + SCW'(1);
					end
				end
				OP_INIT_PUSH: begin
					if (!stat.push_done) begin
						sdepth_q <= sdepth_q + SCW'(1);
					end
				end
				OP_SCAN_CHK: begin
					if (stat.hit) begin
						mft_q <= (mft_q > n_q) ? mft_q - n_q : '0;
					end
				end
				OP_FREE_APPLY: begin
					if (stat.merge_prev || stat.merge_next) begin
						mft_q <= sat_add(mft_q, n_q);
					end
				end
				OP_DN_RD: begin
					if (stat.dn_end) begin
						ext_cnt_q <= ext_cnt_q - ECW'(1);
					end
				end
				OP_INS_PUT: begin
					ext_cnt_q <= ext_cnt_q + ECW'(1);
					mft_q     <= sat_add(mft_q, n_q);
				end
				OP_POP_DATA: sdepth_q <= sdepth_m1;
				default: ;
			endcase
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_MULTI_BASE:  multi_base_q  <= pwdata[PAGE_W-1:0];
					REG_SINGLE_BASE: single_base_q <= pwdata[PAGE_W-1:0];
					REG_END:         end_q         <= pwdata[LEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MULTI_BASE:  prdata = 32'(multi_base_q);
			REG_SINGLE_BASE: prdata = 32'(single_base_q);
			REG_END:         prdata = 32'(end_q);
			default:         prdata = '0;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_granted = out_granted_q;
	assign out_idle    = out_idle_q;

	a_ext_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ext_cnt_q <= ECW'(MAX_EXTENTS))
		else $error("extent count beyond table size");
	a_stk_depth: assert property (@(posedge clk) disable iff (!arst_n)
		sdepth_q <= SCW'(SINGLE_STACK_DEPTH))
		else $error("stack depth beyond stack size");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DONE && stat.out_free) |=> out_valid_q)
		else $error("finished transaction lost its result");
	a_ins_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INS_PUT) |=> (ext_cnt_q == $past(ext_cnt_q) + ECW'(1)))
		else $error("insert did not grow the table");

endmodule

// ----- src/physical_page_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// physical_page_allocator
// First-fit extent allocator with coalescing plus a LIFO single-page stack.
// ----------------------------------------------------------------------------
//  channel   dir   signals                       content
//  s_axis    in    tvalid/tready/tdata[47:0]     action, page, count
//  m_axis    out   tvalid/tready/tdata[47:0]     status, granted_page, idle_pages
//  apb       in    psel/penable/pwrite/paddr     multi_base, single_base, end
//
//  One transaction at a time. Alloc run: reads and checks each extent in turn
//  until one fits or the table ends; a used-up extent is removed by shifting
//  later entries down. Free run: same scan, then apply the merge, or insert by
//  shifting entries up and putting the new one. Page alloc from the stack: pop
//  read, then pop data. Init: one stack push per cycle. Reset clears counts;
//  table and stack contents are not cleared. A stalled result holds in the
//  output register until taken.
module physical_page_allocator import ppa_pkg::*; #(
	parameter int PAGE_NUMBER_BITS   = PNB_DEF,
	parameter int MAX_EXTENTS        = MAX_EXT_DEF,
	parameter int SINGLE_STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_DW-1:0]  s_axis_tdata,  // action[2:0] page[22:3] count[43:23]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_DW-1:0] m_axis_tdata,  // status[1:0] granted_page[21:2] idle_pages[42:22]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	ppa_cmd_t          cmd;
	ppa_stat_t         stat;
	logic [ST_W-1:0]   out_status;
	logic [PAGE_W-1:0] out_granted;
	logic [LEN_W-1:0]  out_idle;

	ppa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppa_dp #(
		.PAGE_NUMBER_BITS   (PAGE_NUMBER_BITS),
		.MAX_EXTENTS        (MAX_EXTENTS),
		.SINGLE_STACK_DEPTH (SINGLE_STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_action   (s_axis_tdata[2:0]),
		.in_page     (s_axis_tdata[22:3]),
		.in_count    (s_axis_tdata[43:23]),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (out_status),
		.out_granted (out_granted),
		.out_idle    (out_idle)
	);

	assign m_axis_tdata = {5'b0, out_idle, out_granted, out_status};
	assign pready       = 1'b1;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the physical page allocator. Requests are queued
// by a stimulus process, driven over the input stream with random gaps, and
// predicted at acceptance against a local model of both free pools. Results
// are checked field by field in order. Four configuration phases cover the
// reset values, the field extremes, an oversized single region and empty pools.
// ----------------------------------------------------------------------------
module tb;
	import ppa_pkg::*;

	localparam logic [ACT_W-1:0] ACT_QUERY = 3'd5;
	localparam int NUM_EXT   = 64;
	localparam int STK_DEPTH = 512;
	localparam longint unsigned PG_LIMIT = 64'd1 << 20;
	localparam longint unsigned LEN_SAT  = 64'h1FFFFF;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [20:0] count;
		logic [19:0] page;
		logic [2:0]  action;
	} pg_req_t;

	typedef struct packed {
		logic [20:0] idle;
		logic [19:0] granted;
		logic [1:0]  status;
	} pg_rsp_t;

	typedef struct {
		longint unsigned page;
		longint unsigned count;
	} run_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_DW-1:0]  s_axis_tdata;   // action[2:0] page[22:3] count[43:23]
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_DW-1:0] m_axis_tdata;   // status[1:0] granted_page[21:2] idle_pages[42:22]
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	physical_page_allocator dut (.*);

	// allocator model state
	longint unsigned cfg_reg [3];
	longint unsigned ext_base [NUM_EXT];
	longint unsigned ext_len [NUM_EXT];
	int              ext_used;
	longint unsigned multi_idle;
	longint unsigned stk [STK_DEPTH];
	int              stk_top;

	pg_req_t pending_reqs[$];
	pg_rsp_t expected_rsps[$];
	run_t    held_runs[$];
	pg_req_t req_on_bus;
	int      sender_gap_pct;
	int      receiver_stall_pct;
	int      errors;
	int      quiet_cycles;

	function automatic longint unsigned sat21(longint unsigned a, longint unsigned b);
		return (a + b > LEN_SAT) ? LEN_SAT : a + b;
	endfunction

	function automatic void drop_extent(int i);
		for (int k = i; k + 1 < ext_used; k++) begin
			ext_base[k] = ext_base[k + 1];
			ext_len[k]  = ext_len[k + 1];
		end
		ext_used--;
	endfunction

	function automatic bit take_run(longint unsigned n, output longint unsigned first);
		first = 0;
		if (n == 0)
			return 0;
		for (int i = 0; i < ext_used; i++) begin
			if (ext_len[i] >= n) begin
				first = (ext_base[i] + ext_len[i] - n) & (PG_LIMIT - 1);
				if (ext_len[i] == n)
					drop_extent(i);
				else
					ext_len[i] -= n;
				multi_idle = (multi_idle > n) ? multi_idle - n : 0;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic logic [ST_W-1:0] give_run(longint unsigned base, longint unsigned n);
		int i;
		bit lo, hi;
		i = 0;
		if (n == 0)
			return ST_OK;
		if (base + n > PG_LIMIT)
			n = PG_LIMIT - base;
		while (i < ext_used && ext_base[i] <= base)
			i++;
		lo = i > 0 && ext_base[i - 1] + ext_len[i - 1] == base;
		hi = i < ext_used && base + n == ext_base[i];
		if (lo && hi) begin
			ext_len[i - 1] = sat21(ext_len[i - 1], sat21(n, ext_len[i]));
			drop_extent(i);
		end else if (lo) begin
			ext_len[i - 1] = sat21(ext_len[i - 1], n);
		end else if (hi) begin
			ext_base[i] = base;
			ext_len[i]  = sat21(ext_len[i], n);
		end else begin
			if (ext_used >= NUM_EXT)
				return ST_TABLE_FULL;
			for (int k = ext_used; k > i; k--) begin
				ext_base[k] = ext_base[k - 1];
				ext_len[k]  = ext_len[k - 1];
			end
			ext_base[i] = base;
			ext_len[i]  = n;
			ext_used++;
		end
		multi_idle = sat21(multi_idle, n);
		return ST_OK;
	endfunction

	function automatic logic [ST_W-1:0] load_pools();
		longint unsigned lim, top;
		logic [ST_W-1:0] st;
		st = ST_OK;
		ext_used   = 0;
		multi_idle = 0;
		stk_top    = 0;
		held_runs.delete();
		lim = (cfg_reg[2] > PG_LIMIT) ? PG_LIMIT : cfg_reg[2];
		top = (cfg_reg[1] < lim) ? cfg_reg[1] : lim;
		if (cfg_reg[0] < top) begin
			ext_base[0] = cfg_reg[0];
			ext_len[0]  = top - cfg_reg[0];
			ext_used    = 1;
			multi_idle  = top - cfg_reg[0];
		end
		for (longint unsigned p = cfg_reg[1]; p < lim; p++) begin
			if (stk_top >= STK_DEPTH) begin
				st = ST_STACK_FULL;
				break;
			end
			stk[stk_top] = p;
			stk_top++;
		end
		return st;
	endfunction

	function automatic pg_rsp_t serve_request(pg_req_t r);
		pg_rsp_t         o;
		longint unsigned g;
		run_t            run;
		o = '0;
		g = 0;
		case (r.action)
			ACT_INIT: o.status = load_pools();
			ACT_RUN_ALLOC: begin
				if (!take_run(r.count, g))
					o.status = ST_NOMEM;
				else begin
					run.page = g; run.count = r.count;
					held_runs.push_back(run);
				end
			end
			ACT_RUN_FREE: o.status = give_run(r.page, r.count);
			ACT_PAGE_ALLOC: begin
				if (stk_top > 0) begin
					stk_top--;
					g = stk[stk_top] & (PG_LIMIT - 1);
				end else if (!take_run(1, g))
					o.status = ST_NOMEM;
				if (o.status == ST_OK) begin
					run.page = g; run.count = 1;
					held_runs.push_back(run);
				end
			end
			ACT_PAGE_FREE: begin
				if (r.page < cfg_reg[1])
					o.status = give_run(r.page, 1);
				else if (stk_top >= STK_DEPTH)
					o.status = ST_STACK_FULL;
				else begin
					stk[stk_top] = r.page;
					stk_top++;
				end
			end
			default: ;
		endcase
		if (o.status == ST_OK || r.action == ACT_INIT)
			o.granted = g[19:0];
		o.idle = 21'(sat21(multi_idle, stk_top));
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_rsps.push_back(serve_request(req_on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
					req_on_bus = pending_reqs.pop_front();
					s_axis_tdata  <= {4'b0, req_on_bus};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		pg_rsp_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			quiet_cycles  <= 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[42:0];
				if (expected_rsps.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
				end else begin
					want = expected_rsps.pop_front();
					if (got.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
					end
					if (got.granted !== want.granted) begin
						errors++;
						$display("%0t: granted_page expected %0d actual %0d",
							$time, want.granted, got.granted);
					end
					if (got.idle !== want.idle) begin
						errors++;
						$display("%0t: idle_pages expected %0d actual %0d",
							$time, want.idle, got.idle);
					end
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= STALL_LIMIT) begin
				$display("physical_page_allocator test failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(int idx, longint unsigned val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'(idx * 4);
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		cfg_reg[idx] = val & ((idx == 2) ? 64'h1FFFFF : 64'hFFFFF);
	endtask

	task automatic queue_req(logic [2:0] a, longint unsigned p, longint unsigned c);
		pg_req_t r;
		r.action = a;
		r.page   = p[19:0];
		r.count  = c[20:0];
		pending_reqs.push_back(r);
	endtask

	task automatic settle();
		wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_rsps.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic setup_phase(longint unsigned mb, longint unsigned sb, longint unsigned ep,
		int gap, int stall);
		settle();
		sender_gap_pct     = gap;
		receiver_stall_pct = stall;
		write_reg(REG_MULTI_BASE, mb);
		write_reg(REG_SINGLE_BASE, sb);
		write_reg(REG_END, ep);
		queue_req(ACT_INIT, 0, 0);
	endtask

	task automatic random_traffic(int n, int noise_pct);
		int   r, j;
		run_t run;
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 15)
				wait (pending_reqs.size() == 0);
			r = $urandom_range(99);
			if (r < noise_pct) begin
				queue_req(3'($urandom_range(7)), $urandom, $urandom);
				continue;
			end
			r = $urandom_range(99);
			if (r >= 30 && r < 55 && held_runs.size() > 0) begin
				j = $urandom_range(held_runs.size() - 1);
				run = held_runs[j];
				held_runs.delete(j);
				if (run.count == 1 && $urandom_range(1))
					queue_req(ACT_PAGE_FREE, run.page, 0);
				else
					queue_req(ACT_RUN_FREE, run.page, run.count);
			end else if (r < 55)
				queue_req(ACT_RUN_ALLOC, 0, ($urandom_range(9) == 0) ?
					$urandom_range(0, 21'h1FFFFF) : $urandom_range(1, 24));
			else if (r < 70)
				queue_req(ACT_PAGE_ALLOC, $urandom, $urandom);
			else if (r < 85)
				queue_req(ACT_PAGE_FREE, $urandom, 0);
			else if (r < 95)
				queue_req(3'($urandom_range(ACT_QUERY, 7)), $urandom, $urandom);
			else
				queue_req(ACT_INIT, 0, 0);
		end
	endtask

	initial begin
		cfg_reg[0] = RST_MULTI_BASE;
		cfg_reg[1] = RST_SINGLE_BASE;
		cfg_reg[2] = RST_END;
		ext_used = 0; multi_idle = 0; stk_top = 0;
		errors = 0;
		sender_gap_pct = 0; receiver_stall_pct = 0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset values; multi extent [524288,525424), 400 pages stacked
		setup_phase(524288, 525424, 525824, 19, 75);
		queue_req(ACT_QUERY, 0, 0);
		queue_req(ACT_RUN_ALLOC, 0, 0);
		queue_req(ACT_RUN_FREE, 77, 0);
		queue_req(ACT_RUN_ALLOC, 0, 21'h1FFFFF);
		queue_req(ACT_RUN_ALLOC, 0, 1);
		queue_req(ACT_RUN_ALLOC, 0, 5);
		queue_req(ACT_RUN_FREE, 525418, 5);
		queue_req(ACT_PAGE_FREE, 525423, 0);
		queue_req(ACT_RUN_FREE, 100, 10);
		queue_req(ACT_RUN_FREE, 90, 10);
		queue_req(ACT_RUN_FREE, 80, 5);
		queue_req(ACT_RUN_FREE, 85, 5);
		queue_req(ACT_RUN_FREE, 20'hFFFFF, 21'h1FFFFF);
		queue_req(ACT_RUN_ALLOC, 0, 20);
		queue_req(ACT_PAGE_ALLOC, 0, 0);
		queue_req(ACT_PAGE_FREE, 20'hFFFFF, 0);
		queue_req(3'd6, 20'hFFFFF, 21'h1FFFFF);
		queue_req(3'd7, 0, 0);
		queue_req(ACT_PAGE_ALLOC, 0, 0);
		random_traffic(190, 5);

		// widest regions
		setup_phase(0, 20'hFFFFF, 21'h100000, 75, 19);
		queue_req(ACT_PAGE_ALLOC, 0, 0);
		queue_req(ACT_PAGE_ALLOC, 0, 0);
		queue_req(ACT_RUN_ALLOC, 0, 21'h100000);
		random_traffic(170, 5);

		// single region larger than the stack
		setup_phase(1000, 2000, 4000, 0, 0);
		queue_req(ACT_PAGE_FREE, 3000, 0);
		queue_req(ACT_PAGE_FREE, 1500, 0);
		random_traffic(170, 5);

		// both pools empty; noisy frees add extents to the table
		setup_phase(12, 12, 5, 0, 0);
		queue_req(ACT_PAGE_ALLOC, 0, 0);
		queue_req(ACT_RUN_ALLOC, 0, 1);
		random_traffic(160, 40);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("physical_page_allocator test passed");
		else
			$display("physical_page_allocator test failed");
		$finish;
	end

endmodule

// ----- physical_page_allocator.f -----
src/ppa_pkg.sv
src/ppa_ram.sv
src/ppa_ctrl.sv
src/ppa_dp.sv
src/physical_page_allocator.sv
tb/tb.sv
